### rtl/websocket_frame_deframer_defines.svh
// Assertion macros shared by the WebSocket deframer RTL.
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset
`define WSFD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset
`define WSFD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/wsfd_pkg.sv
// Types and protocol constants for the WebSocket frame deframer.
package wsfd_pkg;

   // Receive phase, one-hot
   typedef enum logic [4:0] {
      PH_HEADER = 5'b00001,
      PH_DATA   = 5'b00010,
      PH_CTRL   = 5'b00100,
      PH_CLOSED = 5'b01000,
      PH_FAILED = 5'b10000
   } phase_type;

   // Frame opcodes
   localparam logic [3:0] OP_CONT  = 4'h0;
   localparam logic [3:0] OP_TEXT  = 4'h1;
   localparam logic [3:0] OP_BIN   = 4'h2;
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;
   localparam logic [3:0] OP_PONG  = 4'hA;

   // Header fields
   localparam logic [7:0] HDR_FIN_BIT   = 8'h80;
   localparam logic [7:0] HDR_RSV_MASK  = 8'h70;
   localparam logic [7:0] HDR_OP_MASK   = 8'h0F;
   localparam logic [7:0] HDR_MASK_BIT  = 8'h80;
   localparam logic [6:0] LEN7_EXT16    = 7'd126;
   localparam logic [6:0] LEN7_EXT64    = 7'd127;
   localparam logic [31:0] CTRL_MAX_LEN = 32'd125;
   localparam int unsigned HDR_DEPTH    = 14;

   // Byte kinds
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_CTRL = 2'd2;

   // Frame events
   localparam logic [2:0] EV_NONE  = 3'd0;
   localparam logic [2:0] EV_PING  = 3'd1;
   localparam logic [2:0] EV_PONG  = 3'd2;
   localparam logic [2:0] EV_CLOSE = 3'd3;
   localparam logic [2:0] EV_ERROR = 3'd4;

   // Error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_RSV       = 3'd1;
   localparam logic [2:0] ERR_UNMASKED  = 3'd2;
   localparam logic [2:0] ERR_LEN_MSB   = 3'd3;
   localparam logic [2:0] ERR_TOO_LARGE = 3'd4;
   localparam logic [2:0] ERR_TEXT      = 3'd5;
   localparam logic [2:0] ERR_BAD_CTRL  = 3'd6;
   localparam logic [2:0] ERR_UNKNOWN   = 3'd7;

   // Link status
   localparam logic [1:0] LINK_OPEN   = 2'd0;
   localparam logic [1:0] LINK_CLOSED = 2'd1;
   localparam logic [1:0] LINK_FAILED = 2'd2;

   localparam logic [31:0] RESET_MAX_PAYLOAD = 32'd1048576;

   // One result word as held in the output stage
   typedef struct packed {
      logic [1:0] link_status;
      logic [2:0] error_code;
      logic [6:0] reply_len;
      logic [2:0] frame_event;
      logic [6:0] ctrl_index;
      logic [7:0] out_byte;
      logic [1:0] byte_kind;
   } rsp_word_type;

endpackage

### rtl/websocket_frame_deframer.sv
// WebSocket frame deframer: server-side receive state machine, one byte per word.
//
// Usage:
//  - req_* carries one raw client byte per word (after the opening handshake).
//  - rsp_* returns exactly one result word per accepted byte: the unmasked
//    payload byte with its kind in rsp_tuser, the control byte index, the frame
//    event with reply length, an error code and the link status.
//  - csr_wr_en / csr_wr_data set the largest accepted frame payload; write it
//    only while no byte is in flight.
// Timing:
//  - Each byte is decoded by one pass of logic from the header registers, mask
//    key and byte counter into the result register, or into the skid register
//    while rsp is stalled; while rsp flows, one byte per cycle is sustained.
//  - A skid register behind the result register lets one more byte be taken
//    while rsp is stalled; req_tready drops only when both are full.
// Reset (synchronous, active high): phase returns to the frame header, all
// counters and the mask key clear, the payload limit returns to 1 MiB and both
// output stages empty. Failed and closed phases hold until reset.
module websocket_frame_deframer #(
   parameter int unsigned LENGTH_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // input byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] out_byte, [14:8] ctrl_index,
                                    // [17:15] frame_event, [24:18] reply_len,
                                    // [27:25] error_code, [29:28] link_status
   output logic [1:0]  rsp_tuser,   // [1:0] byte_kind
   // payload limit register
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

`include "websocket_frame_deframer_defines.svh"

   // State
   wsfd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  hdr_ff [wsfd_pkg::HDR_DEPTH];
   logic [3:0]  hdr_count_ff, hdr_count_in;
   logic [31:0] mask_key_ff, mask_key_in;
   logic [1:0]  mask_pos_ff, mask_pos_in;
   logic [31:0] bytes_left_ff, bytes_left_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic [6:0]  ctrl_count_ff, ctrl_count_in;
   logic [31:0] max_payload_ff;

   // Output stages
   logic                   out_valid_ff, skid_valid_ff;
   wsfd_pkg::rsp_word_type out_word_ff, skid_word_ff;
   wsfd_pkg::rsp_word_type res;

   logic        req_accept;
   logic        out_free;
   logic [7:0]  rx_byte;
   logic [7:0]  hdr_view [wsfd_pkg::HDR_DEPTH];
   logic [3:0]  cnt_inc;
   logic [3:0]  need;
   logic [6:0]  len7;
   logic        hdr_done;
   logic [63:0] plen;
   logic [31:0] hdr_mask;
   logic        too_large;
   logic [3:0]  hdr_op;
   logic [7:0]  mask_byte;
   logic [31:0] bytes_dec;
   logic        do_finish;
   logic [3:0]  fin_op;
   logic [6:0]  fin_cnt;

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign rx_byte    = req_tdata;

   // Header bytes as they stand with the current byte written in
   always_comb begin
      for (int i = 0; i < wsfd_pkg::HDR_DEPTH; i++) begin
         hdr_view[i] = (hdr_count_ff == 4'(i)) ? rx_byte : hdr_ff[i];
      end
   end

   // Header length and completion
   assign cnt_inc = hdr_count_ff + 4'd1;
   assign len7    = hdr_view[1][6:0];
   assign hdr_op  = hdr_view[0][3:0] & wsfd_pkg::HDR_OP_MASK[3:0];

   always_comb begin
      need = 4'd2;
      if (len7 == wsfd_pkg::LEN7_EXT16) begin
         need = need + 4'd2;
      end else if (len7 == wsfd_pkg::LEN7_EXT64) begin
         need = need + 4'd8;
      end
      if ((hdr_view[1] & wsfd_pkg::HDR_MASK_BIT) != 8'd0) begin
         need = need + 4'd4;
      end
   end

   assign hdr_done = (phase_ff == wsfd_pkg::PH_HEADER) && (cnt_inc >= 4'd2) &&
                     (cnt_inc >= need);

   // Payload length and mask key from the completed header
   always_comb begin
      if (len7 == wsfd_pkg::LEN7_EXT16) begin
         plen     = {48'd0, hdr_view[2], hdr_view[3]};
         hdr_mask = {hdr_view[7], hdr_view[6], hdr_view[5], hdr_view[4]};
      end else if (len7 == wsfd_pkg::LEN7_EXT64) begin
         plen     = {hdr_view[2], hdr_view[3], hdr_view[4], hdr_view[5],
                     hdr_view[6], hdr_view[7], hdr_view[8], hdr_view[9]};
         hdr_mask = {hdr_view[13], hdr_view[12], hdr_view[11], hdr_view[10]};
      end else begin
         plen     = {57'd0, len7};
         hdr_mask = {hdr_view[5], hdr_view[4], hdr_view[3], hdr_view[2]};
      end
   end

   assign too_large = ((plen >> LENGTH_BITS) != 64'd0) || (plen[63:32] != 32'd0) ||
                      (plen[31:0] > max_payload_ff);

   assign mask_byte = mask_key_ff[{mask_pos_ff, 3'b000} +: 8];
   assign bytes_dec = (bytes_left_ff != 32'd0) ? bytes_left_ff - 32'd1 : bytes_left_ff;

   // Per-byte next state and result
   always_comb begin
      phase_in      = phase_ff;
      hdr_count_in  = hdr_count_ff;
      mask_key_in   = mask_key_ff;
      mask_pos_in   = mask_pos_ff;
      bytes_left_in = bytes_left_ff;
      opcode_in     = opcode_ff;
      ctrl_count_in = ctrl_count_ff;
      do_finish     = 1'b0;
      fin_op        = opcode_ff;
      fin_cnt       = 7'd0;
      res           = '0;
      res.byte_kind   = wsfd_pkg::KIND_NONE;
      res.frame_event = wsfd_pkg::EV_NONE;
      res.error_code  = wsfd_pkg::ERR_NONE;

      case (phase_ff)
         wsfd_pkg::PH_HEADER: begin
            hdr_count_in = cnt_inc;
            if (hdr_done) begin
               hdr_count_in = 4'd0;
               mask_key_in  = hdr_mask;
               mask_pos_in  = 2'd0;
               if ((hdr_view[0] & wsfd_pkg::HDR_RSV_MASK) != 8'd0) begin
                  res.error_code = wsfd_pkg::ERR_RSV;
               end else if ((hdr_view[1] & wsfd_pkg::HDR_MASK_BIT) == 8'd0) begin
                  res.error_code = wsfd_pkg::ERR_UNMASKED;
               end else if (len7 == wsfd_pkg::LEN7_EXT64 && plen[63]) begin
                  res.error_code = wsfd_pkg::ERR_LEN_MSB;
               end else if (too_large) begin
                  res.error_code = wsfd_pkg::ERR_TOO_LARGE;
               end else begin
                  case (hdr_op)
                     wsfd_pkg::OP_CONT, wsfd_pkg::OP_BIN: begin
                        opcode_in     = hdr_op;
                        bytes_left_in = plen[31:0];
                        phase_in      = (plen[31:0] == 32'd0) ? wsfd_pkg::PH_HEADER
                                                              : wsfd_pkg::PH_DATA;
                     end
                     wsfd_pkg::OP_TEXT: begin
                        res.error_code = wsfd_pkg::ERR_TEXT;
                     end
                     wsfd_pkg::OP_CLOSE, wsfd_pkg::OP_PING, wsfd_pkg::OP_PONG: begin
                        if ((hdr_view[0] & wsfd_pkg::HDR_FIN_BIT) == 8'd0 ||
                            plen[31:0] > wsfd_pkg::CTRL_MAX_LEN) begin
                           res.error_code = wsfd_pkg::ERR_BAD_CTRL;
                        end else begin
                           opcode_in     = hdr_op;
                           bytes_left_in = plen[31:0];
                           ctrl_count_in = 7'd0;
                           phase_in      = wsfd_pkg::PH_CTRL;
                           do_finish     = (plen[31:0] == 32'd0);
                           fin_op        = hdr_op;
                        end
                     end
                     default: begin
                        res.error_code = wsfd_pkg::ERR_UNKNOWN;
                     end
                  endcase
               end
               // any error code above fails the link
               if (res.error_code != wsfd_pkg::ERR_NONE) begin
                  res.frame_event = wsfd_pkg::EV_ERROR;
                  phase_in        = wsfd_pkg::PH_FAILED;
               end
            end
         end
         wsfd_pkg::PH_DATA: begin
            res.byte_kind = wsfd_pkg::KIND_DATA;
            res.out_byte  = rx_byte ^ mask_byte;
            mask_pos_in   = mask_pos_ff + 2'd1;
            bytes_left_in = bytes_dec;
            if (bytes_dec == 32'd0) begin
               phase_in = wsfd_pkg::PH_HEADER;
            end
         end
         wsfd_pkg::PH_CTRL: begin
            res.byte_kind  = wsfd_pkg::KIND_CTRL;
            res.out_byte   = rx_byte ^ mask_byte;
            res.ctrl_index = ctrl_count_ff;
            mask_pos_in    = mask_pos_ff + 2'd1;
            ctrl_count_in  = ctrl_count_ff + 7'd1;
            bytes_left_in  = bytes_dec;
            do_finish      = (bytes_dec == 32'd0);
            fin_cnt        = ctrl_count_ff + 7'd1;
         end
         default: begin
            // closed or failed: byte is dropped
         end
      endcase

      // End of a control frame: pick the reply
      if (do_finish) begin
         case (fin_op)
            wsfd_pkg::OP_PING: begin
               res.frame_event = wsfd_pkg::EV_PING;
               res.reply_len   = fin_cnt;
               phase_in        = wsfd_pkg::PH_HEADER;
            end
            wsfd_pkg::OP_PONG: begin
               res.frame_event = wsfd_pkg::EV_PONG;
               phase_in        = wsfd_pkg::PH_HEADER;
            end
            default: begin
               res.frame_event = wsfd_pkg::EV_CLOSE;
               res.reply_len   = (fin_cnt >= 7'd2) ? 7'd2 : 7'd0;
               phase_in        = wsfd_pkg::PH_CLOSED;
            end
         endcase
      end

      case (phase_in)
         wsfd_pkg::PH_CLOSED: res.link_status = wsfd_pkg::LINK_CLOSED;
         wsfd_pkg::PH_FAILED: res.link_status = wsfd_pkg::LINK_FAILED;
         default:             res.link_status = wsfd_pkg::LINK_OPEN;
      endcase
   end

   // Parser state and payload limit
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= wsfd_pkg::PH_HEADER;
         hdr_count_ff   <= '0;
         mask_key_ff    <= '0;
         mask_pos_ff    <= '0;
         bytes_left_ff  <= '0;
         opcode_ff      <= '0;
         ctrl_count_ff  <= '0;
         max_payload_ff <= wsfd_pkg::RESET_MAX_PAYLOAD;
      end else begin
         if (csr_wr_en) begin
            max_payload_ff <= csr_wr_data;
         end
         if (req_accept) begin
            phase_ff      <= phase_in;
            hdr_count_ff  <= hdr_count_in;
            mask_key_ff   <= mask_key_in;
            mask_pos_ff   <= mask_pos_in;
            bytes_left_ff <= bytes_left_in;
            opcode_ff     <= opcode_in;
            ctrl_count_ff <= ctrl_count_in;
         end
      end
   end

   // Header byte capture
   always_ff @(posedge clock) begin
      if (req_accept && phase_ff == wsfd_pkg::PH_HEADER &&
          hdr_count_ff < 4'(wsfd_pkg::HDR_DEPTH)) begin
         hdr_ff[hdr_count_ff] <= rx_byte;
      end
   end

   // Result register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff  <= skid_valid_ff || req_accept;
         skid_valid_ff <= 1'b0;
      end else if (req_accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_word_ff <= skid_valid_ff ? skid_word_ff : res;
      end else if (req_accept) begin
         skid_word_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_word_ff.byte_kind;
   assign rsp_tdata  = {2'b00, out_word_ff.link_status, out_word_ff.error_code,
                        out_word_ff.reply_len, out_word_ff.frame_event,
                        out_word_ff.ctrl_index, out_word_ff.out_byte};

   // Checks
   `WSFD_ASSERT_IMP(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff,
      "skid stage holds a word while the result register is empty")
   `WSFD_ASSERT_NXT(a_failed_sticky, clock, reset, phase_ff == wsfd_pkg::PH_FAILED,
      phase_ff == wsfd_pkg::PH_FAILED, "failed phase was left")
   `WSFD_ASSERT_NXT(a_closed_sticky, clock, reset, phase_ff == wsfd_pkg::PH_CLOSED,
      phase_ff == wsfd_pkg::PH_CLOSED, "closed phase was left")
   `WSFD_ASSERT_IMP(a_error_fails_link, clock, reset,
      out_valid_ff && out_word_ff.frame_event == wsfd_pkg::EV_ERROR,
      out_word_ff.error_code != wsfd_pkg::ERR_NONE &&
      out_word_ff.link_status == wsfd_pkg::LINK_FAILED,
      "error event without code or failed status")

endmodule
